FILE: rtl/rcc_pkg.sv
package rcc_pkg;

	localparam int MAX_MODULI       = 4;
	localparam int NUM_MODULI_DEF   = 4;
	localparam int MODULUS_BITS_DEF = 16;
	localparam int FIELD_W          = 16;
	localparam int VALUE_W          = 64;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 16;
	localparam int BITS_PER_STAGE   = 4;

	localparam logic [FIELD_W-1:0] MOD_RST [MAX_MODULI] =
		'{16'd65521, 16'd65519, 16'd65497, 16'd65479};
	localparam logic [FIELD_W-1:0] INV_RST = 16'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODULUS_A = 3'd0,
		CFG_MODULUS_B = 3'd1,
		CFG_MODULUS_C = 3'd2,
		CFG_MODULUS_D = 3'd3,
		CFG_INVERSE_A = 3'd4,
		CFG_INVERSE_B = 3'd5,
		CFG_INVERSE_C = 3'd6,
		CFG_INVERSE_D = 3'd7
	} cfg_idx_t;

	typedef enum logic {
		OP_SPLIT = 1'b0,
		OP_RECON = 1'b1
	} opcode_t;

endpackage

FILE: rtl/rcc_if.sv
interface rcc_in_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [rcc_pkg::VALUE_W-1:0] value_in;
	logic [rcc_pkg::FIELD_W-1:0] residue_in_a;
	logic [rcc_pkg::FIELD_W-1:0] residue_in_b;
	logic [rcc_pkg::FIELD_W-1:0] residue_in_c;
	logic [rcc_pkg::FIELD_W-1:0] residue_in_d;

	modport source (output valid, opcode, value_in, residue_in_a, residue_in_b,
		residue_in_c, residue_in_d, input ready);
	modport sink (input valid, opcode, value_in, residue_in_a, residue_in_b,
		residue_in_c, residue_in_d, output ready);
endinterface

interface rcc_out_if;
	logic                        valid;
	logic                        ready;
	logic [rcc_pkg::FIELD_W-1:0] residue_out_a;
	logic [rcc_pkg::FIELD_W-1:0] residue_out_b;
	logic [rcc_pkg::FIELD_W-1:0] residue_out_c;
	logic [rcc_pkg::FIELD_W-1:0] residue_out_d;
	logic [rcc_pkg::VALUE_W-1:0] value_out;

	modport source (output valid, residue_out_a, residue_out_b, residue_out_c,
		residue_out_d, value_out, input ready);
	modport sink (input valid, residue_out_a, residue_out_b, residue_out_c,
		residue_out_d, value_out, output ready);
endinterface

FILE: rtl/rcc_rem_pipe.sv
module rcc_rem_pipe #(
	parameter int DW = 64,
	parameter int MB = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] dividend,
	input  logic [MB-1:0] divisor,
	output logic [MB-1:0] rem
);

	localparam int BPS = rcc_pkg::BITS_PER_STAGE;
	localparam int NS  = (DW + BPS - 1) / BPS;
	localparam int PW  = NS * BPS;

	logic [MB-1:0] rem_s [NS];
	logic [PW-1:0] num_s [NS];

	function automatic logic [MB-1:0] rem_step(input logic [MB-1:0] r, input logic b,
		input logic [MB-1:0] q);
		logic [MB:0] t;
		t = {r, b};
		if (t >= {1'b0, q}) begin
			t = t - {1'b0, q};
		end
		return t[MB-1:0];
	endfunction

	generate
		for (genvar k = 0; k < NS; k++) begin : g_stage
			logic [MB-1:0] r_in;
			logic [PW-1:0] n_in;
			logic [MB-1:0] r_out;

			if (k == 0) begin : g_first
				assign r_in = '0;
				assign n_in = PW'(dividend);
			end else begin : g_next
				assign r_in = rem_s[k-1];
				assign n_in = num_s[k-1];
			end

			always_comb begin
				r_out = r_in;
				for (int j = 0; j < BPS; j++) begin
					r_out = rem_step(r_out, n_in[PW-1-j], divisor);
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= r_out;
					num_s[k] <= n_in << BPS;
				end
			end
		end
	endgenerate

	assign rem = rem_s[NS-1];

endmodule

FILE: rtl/rcc_cfg.sv
module rcc_cfg #(
	parameter int NUM_MODULI   = rcc_pkg::NUM_MODULI_DEF,
	parameter int MODULUS_BITS = rcc_pkg::MODULUS_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rcc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rcc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [MODULUS_BITS-1:0]           eff_mod [rcc_pkg::MAX_MODULI],
	output logic [MODULUS_BITS-1:0]           inv     [rcc_pkg::MAX_MODULI],
	output logic [3*MODULUS_BITS-1:0]         cof     [rcc_pkg::MAX_MODULI],
	output logic [4*MODULUS_BITS-1:0]         qall
);

	localparam int MB = MODULUS_BITS;
	localparam int NM = rcc_pkg::MAX_MODULI;

	logic [MB-1:0]   mod_q [NM];
	logic [MB-1:0]   inv_q [NM];
	logic [2*MB-1:0] p01_q, p23_q;
	logic [3*MB-1:0] cof_q [NM];
	logic [4*MB-1:0] qall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NM; i++) begin
				mod_q[i] <= MB'(rcc_pkg::MOD_RST[i]);
				inv_q[i] <= MB'(rcc_pkg::INV_RST);
			end
		end else if (cfg_we) begin
			case (cfg_index)
				rcc_pkg::CFG_MODULUS_A: mod_q[0] <= MB'(cfg_data);
				rcc_pkg::CFG_MODULUS_B: mod_q[1] <= MB'(cfg_data);
				rcc_pkg::CFG_MODULUS_C: mod_q[2] <= MB'(cfg_data);
				rcc_pkg::CFG_MODULUS_D: mod_q[3] <= MB'(cfg_data);
				rcc_pkg::CFG_INVERSE_A: inv_q[0] <= MB'(cfg_data);
				rcc_pkg::CFG_INVERSE_B: inv_q[1] <= MB'(cfg_data);
				rcc_pkg::CFG_INVERSE_C: inv_q[2] <= MB'(cfg_data);
				rcc_pkg::CFG_INVERSE_D: inv_q[3] <= MB'(cfg_data);
				default: ;
			endcase
		end
	end

	// inactive lanes and zero moduli act as modulus one
	generate
		for (genvar i = 0; i < NM; i++) begin : g_eff
			if (i < NUM_MODULI) begin : g_act
				assign eff_mod[i] = (mod_q[i] == '0) ? MB'(1) : mod_q[i];
			end else begin : g_off
				assign eff_mod[i] = MB'(1);
			end
			assign inv[i] = inv_q[i];
			assign cof[i] = cof_q[i];
		end
	endgenerate

	// cofactor products settle via p01_q/p23_q, then cof_q and qall_q
	always_ff @(posedge clk) begin
		p01_q    <= (2*MB)'(eff_mod[0]) * (2*MB)'(eff_mod[1]);
		p23_q    <= (2*MB)'(eff_mod[2]) * (2*MB)'(eff_mod[3]);
		qall_q   <= (4*MB)'(p01_q) * (4*MB)'(p23_q);
		cof_q[0] <= (3*MB)'(eff_mod[1]) * (3*MB)'(p23_q);
		cof_q[1] <= (3*MB)'(eff_mod[0]) * (3*MB)'(p23_q);
		cof_q[2] <= (3*MB)'(eff_mod[3]) * (3*MB)'(p01_q);
		cof_q[3] <= (3*MB)'(eff_mod[2]) * (3*MB)'(p01_q);
	end

	assign qall = qall_q;

endmodule

FILE: rtl/rcc_crt_sum.sv
module rcc_crt_sum #(
	parameter int MB = 16
) (
	input  logic            clk,
	input  logic            en,
	input  logic [MB-1:0]   t    [rcc_pkg::MAX_MODULI],
	input  logic [3*MB-1:0] cof  [rcc_pkg::MAX_MODULI],
	input  logic [4*MB-1:0] qall,
	output logic [4*MB-1:0] acc
);

	localparam int NM = rcc_pkg::MAX_MODULI;
	localparam int AW = 4 * MB;

	logic [AW-1:0] term_s1 [NM];
	logic [AW-1:0] half_s2 [2];
	logic [AW-1:0] acc_s3;

	function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW-1:0] b,
		input logic [AW-1:0] q);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, q}) begin
			s = s - {1'b0, q};
		end
		return s[AW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NM; i++) begin
				term_s1[i] <= AW'(t[i]) * AW'(cof[i]);
			end
			half_s2[0] <= add_mod(term_s1[0], term_s1[1], qall);
			half_s2[1] <= add_mod(term_s1[2], term_s1[3], qall);
			acc_s3     <= add_mod(half_s2[0], half_s2[1], qall);
		end
	end

	assign acc = acc_s3;

endmodule

FILE: rtl/rns_crt_convert_unit.sv
// RNS / CRT converter.
// req carries one word per item: opcode selects split (value_in into four
// residues) or reconstruct (residue_in_a..d into value_out modulo Q, the
// product of the moduli). rsp returns one word per item, in order; the
// fields the opcode does not use are zero.
// The user writes moduli and inverses on cfg_we/cfg_index/cfg_data only
// while no item is in flight, which the block does not enforce; inverses
// of Q/q_i modulo q_i come from software. At 16-bit moduli the split
// path is a 64-bit restoring remainder, 4 bits per stage (16 stages),
// plus the output register. The reconstruct path (product, 8 remainder
// stages, cofactor multiply, two-level modular add tree) is padded to
// the same depth. Throughput is one word per cycle unless rsp stalls.
// Reset restores the default moduli and unit inverses and empties the
// pipeline. A stall on rsp freezes the whole pipeline and drops
// req.ready until the output word is taken; nothing is lost or repeated.
module rns_crt_convert_unit #(
	parameter int NUM_MODULI   = rcc_pkg::NUM_MODULI_DEF,
	parameter int MODULUS_BITS = rcc_pkg::MODULUS_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rcc_in_if.sink                         req,
	rcc_out_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [rcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int MB   = MODULUS_BITS;
	localparam int NM   = rcc_pkg::MAX_MODULI;
	localparam int BPS  = rcc_pkg::BITS_PER_STAGE;
	localparam int FW   = rcc_pkg::FIELD_W;
	localparam int VW   = rcc_pkg::VALUE_W;
	localparam int RW   = FW + MB;
	localparam int FL   = (VW + BPS - 1) / BPS;
	localparam int RL   = (RW + BPS - 1) / BPS;
	localparam int CL   = RL + 4;
	localparam int CORE = (FL > CL) ? FL : CL;
	localparam int LAT  = CORE + 1;

	logic              en;
	logic [LAT-1:0]    v_s;
	logic [LAT-1:0]    op_s;
	logic [MB-1:0]     eff_mod [NM];
	logic [MB-1:0]     inv     [NM];
	logic [3*MB-1:0]   cof     [NM];
	logic [4*MB-1:0]   qall;
	logic [FW-1:0]     res_in  [NM];
	logic [RW-1:0]     prod_s1 [NM];
	logic [MB-1:0]     t_rem   [NM];
	logic [NM*MB-1:0]  fwd_flat, fwd_al;
	logic [4*MB-1:0]   rec_acc, rec_al;
	logic [FW-1:0]     res_out_q [NM];
	logic [VW-1:0]     val_out_q;

	assign en        = !v_s[LAT-1] || rsp.ready;
	assign req.ready = en;

	assign res_in[0] = req.residue_in_a;
	assign res_in[1] = req.residue_in_b;
	assign res_in[2] = req.residue_in_c;
	assign res_in[3] = req.residue_in_d;

	rcc_cfg #(
		.NUM_MODULI   (NUM_MODULI),
		.MODULUS_BITS (MODULUS_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.eff_mod   (eff_mod),
		.inv       (inv),
		.cof       (cof),
		.qall      (qall)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[LAT-2:0], req.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s <= {op_s[LAT-2:0], req.opcode};
			for (int i = 0; i < NM; i++) begin
				prod_s1[i] <= RW'(res_in[i]) * RW'(inv[i]);
			end
		end
	end

	generate
		for (genvar i = 0; i < NM; i++) begin : g_lane
			rcc_rem_pipe #(.DW(VW), .MB(MB)) u_fwd (
				.clk      (clk),
				.en       (en),
				.dividend (req.value_in),
				.divisor  (eff_mod[i]),
				.rem      (fwd_flat[i*MB +: MB])
			);
			rcc_rem_pipe #(.DW(RW), .MB(MB)) u_rec (
				.clk      (clk),
				.en       (en),
				.dividend (prod_s1[i]),
				.divisor  (eff_mod[i]),
				.rem      (t_rem[i])
			);
		end
	endgenerate

	rcc_crt_sum #(.MB(MB)) u_sum (
		.clk  (clk),
		.en   (en),
		.t    (t_rem),
		.cof  (cof),
		.qall (qall),
		.acc  (rec_acc)
	);

	generate
		if (CORE > FL) begin : g_fpad
			logic [NM*MB-1:0] fpad_s [CORE-FL];
			always_ff @(posedge clk) begin
				if (en) begin
					fpad_s[0] <= fwd_flat;
					for (int k = 1; k < CORE - FL; k++) begin
						fpad_s[k] <= fpad_s[k-1];
					end
				end
			end
			assign fwd_al = fpad_s[CORE-FL-1];
		end else begin : g_fnopad
			assign fwd_al = fwd_flat;
		end

		if (CORE > CL) begin : g_rpad
			logic [4*MB-1:0] rpad_s [CORE-CL];
			always_ff @(posedge clk) begin
				if (en) begin
					rpad_s[0] <= rec_acc;
					for (int k = 1; k < CORE - CL; k++) begin
						rpad_s[k] <= rpad_s[k-1];
					end
				end
			end
			assign rec_al = rpad_s[CORE-CL-1];
		end else begin : g_rnopad
			assign rec_al = rec_acc;
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NM; i++) begin
				res_out_q[i] <= (op_s[CORE-1] == rcc_pkg::OP_SPLIT) ?
					FW'(fwd_al[i*MB +: MB]) : '0;
			end
			val_out_q <= (op_s[CORE-1] == rcc_pkg::OP_RECON) ? VW'(rec_al) : '0;
		end
	end

	assign rsp.valid         = v_s[LAT-1];
	assign rsp.residue_out_a = res_out_q[0];
	assign rsp.residue_out_b = res_out_q[1];
	assign rsp.residue_out_c = res_out_q[2];
	assign rsp.residue_out_d = res_out_q[3];
	assign rsp.value_out     = val_out_q;

`ifndef NO_ASSERTIONS
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("input taken while output word stalled");

	a_recon_below_q: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && op_s[LAT-1] == rcc_pkg::OP_RECON |-> rsp.value_out < VW'(qall))
		else $error("reconstructed word not reduced modulo Q");

	a_split_residue_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && op_s[LAT-1] == rcc_pkg::OP_SPLIT |->
			rsp.residue_out_a < FW'(eff_mod[0]) && rsp.value_out == '0)
		else $error("split word residue out of range");
`endif

endmodule
